>>> rtl/mbrp_pkg.sv
// Shared types, constants and helpers for the MBR partition table parser.
package mbrp_pkg;

  localparam int unsigned TableEntries = 4;
  localparam int unsigned EntryW       = 2;
  localparam int unsigned PosW         = 10;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [PosW-1:0] TableBase   = 10'h1BE;
  localparam logic [PosW-1:0] SigPos      = 10'h1FE;
  localparam logic [PosW-1:0] SigPosHigh  = 10'h1FF;
  localparam logic [15:0]     SectorBytes = 16'd512;

  localparam logic [7:0] SigLow  = 8'h55;
  localparam logic [7:0] SigHigh = 8'hAA;

  // partition type codes
  localparam logic [7:0] TypeFat12     = 8'h01;
  localparam logic [7:0] TypeFat16Sm   = 8'h04;
  localparam logic [7:0] TypeFat16     = 8'h06;
  localparam logic [7:0] TypeNtfs      = 8'h07;
  localparam logic [7:0] TypeFat32     = 8'h0B;
  localparam logic [7:0] TypeFat32Lba  = 8'h0C;
  localparam logic [7:0] TypeFat16Lba  = 8'h0E;
  localparam logic [7:0] TypeExtLba    = 8'h0F;
  localparam logic [7:0] TypeLinux     = 8'h83;

  // entry offsets within a 16-byte table entry
  localparam logic [3:0] OffType = 4'h4;
  localparam logic [1:0] QuadStart  = 2'b10;
  localparam logic [1:0] QuadLength = 2'b11;

  localparam logic [CfgIdxW-1:0] CfgIdxBlockSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxBlockCount = 1'b1;

  typedef enum logic [1:0] {
    StatusFat     = 2'd0,
    StatusExt     = 2'd1,
    StatusInvalid = 2'd2,
    StatusReject  = 2'd3
  } entry_status_e;

  // snapshot of one finished block, handed from front to back
  typedef struct packed {
    logic                               reject;
    logic [31:0]                        dev_blocks;
    logic [TableEntries-1:0][7:0]       types;
    logic [TableEntries-1:0][31:0]      starts;
    logic [TableEntries-1:0][31:0]      lengths;
  } job_t;

  function automatic logic type_is_fat(input logic [7:0] t);
    logic fat;
    case (t) inside
      TypeFat12, TypeFat16Sm, TypeFat16, TypeNtfs,
      TypeFat32, TypeFat32Lba, TypeFat16Lba, TypeExtLba: fat = 1'b1;
      default: fat = 1'b0;
    endcase
    return fat;
  endfunction

endpackage

>>> rtl/mbrp_front.sv
// Byte intake: tracks position, captures table entries and signature, emits block snapshots.
module mbrp_front import mbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        read_error_i,
  input  logic        last_byte_i,
  input  logic [15:0] block_size_i,
  input  logic [31:0] dev_blocks_i,
  output logic        job_push_o,
  output job_t        job_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_upd, rel;
  logic [7:0]      sig_lo_q, sig_lo_d, sig_lo_upd;
  logic [7:0]      sig_hi_q, sig_hi_d, sig_hi_upd;
  logic            err_q, err_d, err_upd;
  logic [7:0]      type_q  [TableEntries];
  logic [7:0]      type_d  [TableEntries];
  logic [31:0]     start_q [TableEntries];
  logic [31:0]     start_d [TableEntries];
  logic [31:0]     len_q   [TableEntries];
  logic [31:0]     len_d   [TableEntries];
  logic            in_range, in_table;
  logic [EntryW-1:0] ent;
  logic [3:0]      off;

  assign in_range = ~pos_q[PosW-1];  // below 512
  assign rel      = pos_q - TableBase;
  assign in_table = in_range && (pos_q >= TableBase) && (pos_q < SigPos);
  assign ent      = rel[5:4];
  assign off      = rel[3:0];

  always_comb begin
    pos_upd    = pos_q;
    sig_lo_upd = sig_lo_q;
    sig_hi_upd = sig_hi_q;
    err_upd    = err_q;
    for (int e = 0; e < TableEntries; e++) begin
      type_d[e]  = type_q[e];
      start_d[e] = start_q[e];
      len_d[e]   = len_q[e];
    end
    if (byte_valid_i) begin
      err_upd = err_q | read_error_i;
      if (in_range) begin
        pos_upd = pos_q + PosW'(1);
      end
      if (pos_q == SigPos) begin
        sig_lo_upd = data_byte_i;
      end
      if (pos_q == SigPosHigh) begin
        sig_hi_upd = data_byte_i;
      end
      for (int e = 0; e < TableEntries; e++) begin
        if (in_table && ent == EntryW'(e)) begin
          if (off == OffType) begin
            type_d[e] = data_byte_i;
          end else if (off[3:2] == QuadStart) begin
            start_d[e][{off[1:0], 3'b000} +: 8] = data_byte_i;
          end else if (off[3:2] == QuadLength) begin
            len_d[e][{off[1:0], 3'b000} +: 8] = data_byte_i;
          end
        end
      end
    end
  end

  assign job_push_o = byte_valid_i && last_byte_i;

  always_comb begin
    job_o.reject = err_upd || (block_size_i < SectorBytes) || (dev_blocks_i == 32'd0) ||
                   (sig_lo_upd != SigLow) || (sig_hi_upd != SigHigh);
    job_o.dev_blocks = dev_blocks_i;
    for (int e = 0; e < TableEntries; e++) begin
      job_o.types[e]   = type_d[e];
      job_o.starts[e]  = start_d[e];
      job_o.lengths[e] = len_d[e];
    end
  end

  // block end clears position, signature and error; entry stores persist
  always_comb begin
    if (job_push_o) begin
      pos_d    = '0;
      sig_lo_d = '0;
      sig_hi_d = '0;
      err_d    = 1'b0;
    end else begin
      pos_d    = pos_upd;
      sig_lo_d = sig_lo_upd;
      sig_hi_d = sig_hi_upd;
      err_d    = err_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sig_lo_q <= '0;
      sig_hi_q <= '0;
      err_q    <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      sig_lo_q <= sig_lo_d;
      sig_hi_q <= sig_hi_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int e = 0; e < TableEntries; e++) begin
      type_q[e]  <= type_d[e];
      start_q[e] <= start_d[e];
      len_q[e]   <= len_d[e];
    end
  end

endmodule

>>> rtl/mbrp_queue.sv
// Short FIFO of block snapshots between intake and result generation.
module mbrp_queue import mbrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic empty_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

>>> rtl/mbrp_back.sv
// Result generation: walks the entries of a snapshot, classifies each, holds the result.
module mbrp_back import mbrp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [EntryW-1:0] entry_number_o,
  output logic [1:0]        entry_status_o,
  output logic [31:0]       start_sector_o,
  output logic [31:0]       sector_total_o,
  output logic              last_entry_o
);

  localparam logic [EntryW-1:0] LastIdx = EntryW'(TableEntries - 1);

  logic [EntryW-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic              load, idx_last;
  logic [7:0]        etype;
  logic [31:0]       est, elen;
  logic [32:0]       extent_end;
  logic              out_of_range;
  entry_status_e     status;
  logic [31:0]       res_start, res_total;

  assign idx_last  = (idx_q == LastIdx);
  assign load      = job_valid_i && (!out_valid_q || pop_i);
  assign job_pop_o = load && idx_last;

  assign etype      = job_i.types[idx_q];
  assign est        = job_i.starts[idx_q];
  assign elen       = job_i.lengths[idx_q];
  // 33-bit sum so a large start plus length cannot wrap
  assign extent_end = {1'b0, est} + {1'b0, elen};
  assign out_of_range = (est >= job_i.dev_blocks) || (extent_end > {1'b0, job_i.dev_blocks});

  always_comb begin
    res_start = est;
    res_total = elen;
    if (job_i.reject) begin
      status    = StatusReject;
      res_start = '0;
      res_total = '0;
    end else if (out_of_range) begin
      status = StatusInvalid;
    end else if (type_is_fat(etype)) begin
      status = StatusFat;
    end else if (etype == TypeLinux) begin
      status = StatusExt;
    end else begin
      status = StatusInvalid;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = idx_last ? '0 : idx_q + EntryW'(1);
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_number_o <= idx_q;
      entry_status_o <= status;
      start_sector_o <= res_start;
      sector_total_o <= res_total;
      last_entry_o   <= idx_last;
    end
  end

  assign empty_o = !out_valid_q;

endmodule

>>> rtl/mbr_partition_table_parser_top.sv
// Top level of the MBR partition table parser: config registers, front, queue, back.
//
//   channel  direction  transfer when              payload
//   bytes    in         push & !full               data_byte_i, read_error_i, last_byte_i
//   results  out        pop & !empty               entry_number_o .. last_entry_o
//   config   in         cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// Bytes are taken one per cycle while the queue is not full. Each last byte queues a block
// snapshot; the back end emits its four results, one per entry, from one 33-bit extent
// adder. The snapshot queue holds two blocks; full rises only when both slots wait.
// Reset clears control state only; no clearing pass. Config is always ready.
module mbr_partition_table_parser_top import mbrp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte_i,
  input  logic               read_error_i,
  input  logic               last_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic [EntryW-1:0]  entry_number_o,
  output logic [1:0]         entry_status_o,
  output logic [31:0]        start_sector_o,
  output logic [31:0]        sector_total_o,
  output logic               last_entry_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [15:0] block_size_q;
  logic [31:0] dev_blocks_q;
  logic        byte_valid;
  logic        q_push, q_full, q_empty, q_pop;
  job_t        q_in, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= SectorBytes;
      dev_blocks_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgIdxBlockSize:  block_size_q <= cfg_data_i[15:0];
        CfgIdxBlockCount: dev_blocks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full       = q_full;
  assign byte_valid = push && !full;

  mbrp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid),
    .data_byte_i   (data_byte_i),
    .read_error_i  (read_error_i),
    .last_byte_i   (last_byte_i),
    .block_size_i  (block_size_q),
    .dev_blocks_i  (dev_blocks_q),
    .job_push_o    (q_push),
    .job_o         (q_in)
  );

  mbrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  mbrp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!q_empty),
    .job_i          (q_head),
    .job_pop_o      (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .entry_number_o (entry_number_o),
    .entry_status_o (entry_status_o),
    .start_sector_o (start_sector_o),
    .sector_total_o (sector_total_o),
    .last_entry_o   (last_entry_o)
  );

`ifndef NO_ASSERTIONS
  // a snapshot never goes into a full queue
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("snapshot pushed into full queue");

  // a block end leaves a snapshot waiting for the back end
  a_block_end_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && last_byte_i) |=> !q_empty)
    else $error("block end did not queue a snapshot");

  // taking a result that is not the last of its block leaves the next one ready
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_entry_o) |=> !empty)
    else $error("gap between results of one block");
`endif

endmodule
